// File: hdl/bitmap_frame_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BFA_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Frame allocator package
// Field widths, request and status codes, datapath types and map word helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned FIELD_W = 48;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned ALU_W   = FIELD_W + 1;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WORD_SH = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_FRAMES_DEF   = 65536;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned ADDRESS_BITS_DEF = 48;

  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(65536);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_FREE_RG = 2'd2,
    REQ_RSV_RG  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_e;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_res_t;

  function automatic logic [WORD_SH:0] pop_word(input logic [WORD_W-1:0] w);
    logic [WORD_SH:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + (WORD_SH+1)'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [WORD_SH-1:0] low_bit(input logic [WORD_W-1:0] w);
    logic [WORD_SH-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = WORD_SH'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [WORD_W-1:0] rng_mask(input logic [WORD_SH-1:0] lo,
                                                 input logic [WORD_SH:0]   hi);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = ((WORD_SH+1)'(i) >= {1'b0, lo}) && ((WORD_SH+1)'(i) < hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bfa_alu.sv
// ----------------------------------------------------------------------------
// Frame allocator shared adder
// One wide add/subtract unit with carry out, time-shared by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_alu (
  input  bfa_pkg::alu_ctl_t           ctl_i,
  input  logic [bfa_pkg::ALU_W-1:0]   a_i,
  input  logic [bfa_pkg::ALU_W-1:0]   b_i,
  output bfa_pkg::alu_res_t           res_o
);
  import bfa_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   total;

  assign b_op  = ctl_i.sub ? ~b_i : b_i;
  assign total = {1'b0, a_i} + {1'b0, b_op} + (ALU_W+1)'(ctl_i.sub);

  assign res_o.sum   = total[ALU_W-1:0];
  assign res_o.carry = total[ALU_W];

endmodule

`default_nettype wire

// File: hdl/bfa_map.sv
// ----------------------------------------------------------------------------
// Frame allocator used map
// One bit per frame in 32-bit words, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_map #(
  parameter int unsigned WORDS = 2048,
  parameter int unsigned WA    = 11
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [WA-1:0]                waddr_i,
  input  logic [bfa_pkg::WORD_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [WA-1:0]                raddr_i,
  output logic [bfa_pkg::WORD_W-1:0]   rdata_o
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// Next-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high until
// its single result is shown on done_o for one cycle, and the receiver cannot
// stall it. After reset the map is filled with "used" one word per cycle,
// ceil(MAX_FRAMES/32) words (2048 by default), with busy high. An allocate
// scans map words from the next-fit hint and wraps once to frame zero; it
// ends with out-of-memory at once when the free count is zero, or after a
// scan that finds no free frame. A free, a region free or a reserve updates
// each map word that it touches. A request whose address is below base, or
// whose frame is at or beyond the limit, ends with the range status. Map
// words are changed by read-modify-write, and the one shared adder does
// every wide step.
`default_nettype none
`include "bitmap_frame_allocator_top_defines.svh"

module bitmap_frame_allocator_top #(
  parameter int unsigned MAX_FRAMES   = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BYTES   = bfa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS = bfa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type_i,
  input  logic [bfa_pkg::FIELD_W-1:0]       address_i,
  input  logic [bfa_pkg::FIELD_W-1:0]       region_size_i,
  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bfa_pkg::FIELD_W-1:0]       cfg_wdata_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [bfa_pkg::FIELD_W-1:0]       frame_address_o,
  output logic [bfa_pkg::CNT_W-1:0]         free_count_o
);
  import bfa_pkg::*;

  localparam int unsigned WORDS   = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned WA      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SHIFT   = $clog2(PAGE_BYTES);
  localparam int unsigned AW      = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
  localparam int unsigned CUR_W   = CNT_W + 1;
  localparam int unsigned LIM_CAP = (MAX_FRAMES < (2**CNT_W - 1)) ? MAX_FRAMES
                                                                  : (2**CNT_W - 1);
  localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - AW);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_RANGE = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_END   = 4'd5;
  localparam logic [3:0] S_CLIP  = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;
  localparam logic [3:0] S_FADDR = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [WA-1:0]      clr_q, clr_d;
  logic [FIELD_W-1:0] base_q;
  logic [CNT_W-1:0]   limit_q;
  logic [1:0]         req_q, req_d;
  logic [FIELD_W-1:0] addr_q, addr_d;
  logic [FIELD_W-1:0] size_q, size_d;
  logic [ALU_W-1:0]   tmp_q, tmp_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   end_q, end_d;
  logic               phase_q, phase_d;
  logic [CNT_W-1:0]   hit_q, hit_d;
  logic [CNT_W-1:0]   hint_q, hint_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [WORD_SH:0]   pop_q, pop_d;
  logic               acc_q, acc_d;
  logic               done_q, done_d;
  logic [1:0]         stat_q, stat_d;
  logic [FIELD_W-1:0] faddr_q, faddr_d;

  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   start_w;
  alu_ctl_t           alu_ctl;
  logic [ALU_W-1:0]   alu_a, alu_b;
  alu_res_t           alu_res;

  logic               map_we, map_re;
  logic [WA-1:0]      map_waddr, map_raddr;
  logic [WORD_W-1:0]  map_wdata, map_rdata;

  logic [CUR_W-1:0]   word_end;
  logic [WORD_SH:0]   hi_bit;
  logic [WORD_W-1:0]  win, free_bits, change;
  logic [WORD_SH-1:0] bit_idx;

  assign lim     = (limit_q < CNT_W'(LIM_CAP)) ? limit_q : CNT_W'(LIM_CAP);
  assign start_w = CNT_W'(tmp_q >> SHIFT);

  assign word_end  = {cur_q[CUR_W-1:WORD_SH] + (CUR_W-WORD_SH)'(1), {WORD_SH{1'b0}}};
  assign hi_bit    = ({1'b0, end_q} >= word_end) ? (WORD_SH+1)'(WORD_W)
                                                 : {1'b0, end_q[WORD_SH-1:0]};
  assign win       = rng_mask(cur_q[WORD_SH-1:0], hi_bit);
  assign free_bits = ~map_rdata & win;
  assign bit_idx   = low_bit(free_bits);
  assign change    = (req_q == REQ_RSV_RG) ? (~map_rdata & win) : (map_rdata & win);

  bfa_alu u_alu (
    .ctl_i (alu_ctl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  bfa_map #(
    .WORDS (WORDS),
    .WA    (WA)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    req_d     = req_q;
    addr_d    = addr_q;
    size_d    = size_q;
    tmp_d     = tmp_q;
    cur_d     = cur_q;
    end_d     = end_q;
    phase_d   = phase_q;
    hit_d     = hit_q;
    hint_d    = hint_q;
    free_d    = free_q;
    pop_d     = pop_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    stat_d    = stat_q;
    faddr_d   = faddr_q;
    alu_ctl   = '0;
    alu_a     = '0;
    alu_b     = '0;
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_waddr = WA'(cur_q >> WORD_SH);
    map_raddr = WA'(cur_q >> WORD_SH);
    map_wdata = map_rdata;

    case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = {WORD_W{1'b1}};
        if (clr_q == WA'(WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + WA'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d   = req_type_i;
          addr_d  = address_i & ADDR_MASK;
          size_d  = region_size_i & ADDR_MASK;
          faddr_d = '0;
          stat_d  = ST_OK;
          acc_d   = 1'b0;
          if (req_type_i == REQ_ALLOC) begin
            if (free_q == '0) begin
              stat_d  = ST_OOM;
              state_d = S_FIN;
            end else begin
              cur_d   = CUR_W'(hint_q);
              end_d   = lim;
              phase_d = 1'b0;
              state_d = S_CHK;
            end
          end else begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        alu_ctl.sub = 1'b1;
        alu_a       = ALU_W'(addr_q);
        alu_b       = ALU_W'(base_q & ADDR_MASK);
        if (!alu_res.carry) begin
          stat_d  = ST_RANGE;
          state_d = S_FIN;
        end else begin
          tmp_d   = alu_res.sum;
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        alu_ctl.sub = 1'b1;
        alu_a       = tmp_q >> SHIFT;
        alu_b       = ALU_W'(lim);
        if (alu_res.carry) begin
          stat_d  = ST_RANGE;
          state_d = S_FIN;
        end else begin
          cur_d = CUR_W'(start_w);
          if (req_q == REQ_FREE) begin
            end_d   = start_w + CNT_W'(1);
            state_d = S_CHK;
          end else begin
            state_d = S_CNT;
          end
        end
      end
      S_CNT: begin
        alu_a   = ALU_W'(size_q);
        alu_b   = (req_q == REQ_RSV_RG) ? ALU_W'(PAGE_BYTES - 1) : '0;
        tmp_d   = alu_res.sum >> SHIFT;
        state_d = S_END;
      end
      S_END: begin
        alu_a   = ALU_W'(cur_q);
        alu_b   = tmp_q;
        tmp_d   = alu_res.sum;
        state_d = S_CLIP;
      end
      S_CLIP: begin
        alu_ctl.sub = 1'b1;
        alu_a       = ALU_W'(lim);
        alu_b       = tmp_q;
        end_d       = alu_res.carry ? tmp_q[CNT_W-1:0] : lim;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (acc_q) begin
          acc_d = 1'b0;
          if (req_q == REQ_RSV_RG) begin
            free_d = (free_q > CNT_W'(pop_q)) ? (free_q - CNT_W'(pop_q)) : '0;
          end else begin
            free_d = free_q + CNT_W'(pop_q);
          end
        end
        if (cur_q >= CUR_W'(end_q)) begin
          if (req_q == REQ_ALLOC) begin
            if (!phase_q) begin
              phase_d = 1'b1;
              cur_d   = '0;
              end_d   = (hint_q < lim) ? hint_q : lim;
            end else begin
              stat_d  = ST_OOM;
              state_d = S_FIN;
            end
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        map_re  = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (req_q == REQ_ALLOC) begin
          if (free_bits != '0) begin
            map_we    = 1'b1;
            map_wdata = map_rdata | (WORD_W'(1) << bit_idx);
            hit_d     = {cur_q[CNT_W-1:WORD_SH], bit_idx};
            hint_d    = {cur_q[CNT_W-1:WORD_SH], bit_idx} + CNT_W'(1);
            free_d    = free_q - CNT_W'(1);
            state_d   = S_FADDR;
          end else begin
            cur_d   = word_end;
            state_d = S_CHK;
          end
        end else begin
          map_we    = 1'b1;
          map_wdata = (req_q == REQ_RSV_RG) ? (map_rdata | win) : (map_rdata & ~win);
          pop_d     = pop_word(change);
          acc_d     = 1'b1;
          if ((req_q == REQ_FREE) && (change != '0) && (cur_q[CNT_W-1:0] < hint_q)) begin
            hint_d = cur_q[CNT_W-1:0];
          end
          cur_d   = word_end;
          state_d = S_CHK;
        end
      end
      S_FADDR: begin
        alu_a   = ALU_W'(base_q & ADDR_MASK);
        alu_b   = ALU_W'(hit_q) << SHIFT;
        faddr_d = alu_res.sum[FIELD_W-1:0] & ADDR_MASK;
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      base_q  <= '0;
      limit_q <= LIMIT_RST;
      hint_q  <= '0;
      free_q  <= '0;
      acc_q   <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      stat_q  <= ST_OK;
      faddr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      free_q  <= free_d;
      acc_q   <= acc_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      stat_q  <= stat_d;
      faddr_q <= faddr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE:  base_q  <= cfg_wdata_i;
          CFG_LIMIT: limit_q <= cfg_wdata_i[CNT_W-1:0];
          default:   base_q  <= base_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    addr_q <= addr_d;
    size_q <= size_d;
    tmp_q  <= tmp_d;
    cur_q  <= cur_d;
    end_q  <= end_d;
    hit_q  <= hit_d;
    pop_q  <= pop_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = stat_q;
  assign frame_address_o = faddr_q;
  assign free_count_o    = free_q;

  `BFA_ASSERT_HOLDS(a_done_idle, done_o, !busy, "result strobe while busy")
  `BFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "request not taken up")
  `BFA_ASSERT_HOLDS(a_faddr_zero, done_o && (status_o != ST_OK), frame_address_o == '0,
                    "frame address on failed request")
  `BFA_ASSERT_NEXT(a_idle_count, !busy && !start, $stable(free_count_o),
                   "free count moved while idle")

endmodule

`default_nettype wire
